@@ hw/rtl/rdtt_pkg.sv @@
// Package for the duplicate-request tracking table: constants, codes and types.
// Used by the channel interfaces and every module of the block.
package rdtt_pkg;

  localparam int DEF_NUM_CODES = 64;
  localparam int MAX_CODES     = 64;    // allowed-codes register is 64 bits wide
  localparam int IDS_PER_CODE  = 256;
  localparam int Q_DEPTH       = 2;

  localparam int OP_W     = 2;
  localparam int CODE_W   = 8;
  localparam int IDENT_W  = 8;
  localparam int PLEN_W   = 16;
  localparam int WORD_W   = 64;
  localparam int RLEN_W   = 13;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 15;

  localparam logic [RLEN_W-1:0] MAX_REPLY = RLEN_W'(4096);

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
  localparam logic [OP_W-1:0] OP_REPLY  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NEW  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_SAME = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DIFF = 3'd3;
  localparam logic [STATUS_W-1:0] ST_ERR  = 3'd4;

  // Command kinds decided by the front end
  typedef enum logic [2:0] {
    K_INS,    // insert, valid code, nonzero stamp
    K_DEL,    // delete
    K_RPL,    // record reply
    K_LOOK,   // valid code but rejected op: error, entry's reply length shown
    K_BAD     // no table for this code: error, nothing shown
  } kind_t;

  typedef struct packed {
    kind_t               kind;
    logic [CODE_W-1:0]   code;
    logic [IDENT_W-1:0]  ident;
    logic [PLEN_W-1:0]   pkt_length;
    logic [WORD_W-1:0]   auth_hi;
    logic [WORD_W-1:0]   auth_lo;
    logic [WORD_W-1:0]   stamp;
    logic [RLEN_W-1:0]   reply_length;
  } cmd_t;

  // One table entry; ts == 0 marks it unused
  typedef struct packed {
    logic [WORD_W-1:0]  ts;
    logic [PLEN_W-1:0]  len;
    logic [WORD_W-1:0]  auth_hi;
    logic [WORD_W-1:0]  auth_lo;
    logic [RLEN_W-1:0]  held_rlen;
  } entry_t;

endpackage

@@ hw/rtl/rdtt_in_if.sv @@
// Request channel interface: valid/ready handshake plus the request header fields.
// Depends on rdtt_pkg.
interface rdtt_in_if import rdtt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     op;
  logic [CODE_W-1:0]   code;
  logic [IDENT_W-1:0]  ident;
  logic [PLEN_W-1:0]   pkt_length;
  logic [WORD_W-1:0]   auth_hi;
  logic [WORD_W-1:0]   auth_lo;
  logic [WORD_W-1:0]   stamp;
  logic [RLEN_W-1:0]   reply_length;

  modport source (output valid, op, code, ident, pkt_length, auth_hi, auth_lo, stamp,
                  reply_length, input ready);
  modport sink (input valid, op, code, ident, pkt_length, auth_hi, auth_lo, stamp,
                reply_length, output ready);
endinterface

@@ hw/rtl/rdtt_out_if.sv @@
// Result channel interface: valid/ready handshake plus status, count and reply length.
// Depends on rdtt_pkg.
interface rdtt_out_if import rdtt_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [STATUS_W-1:0]  status;
  logic [COUNT_W-1:0]   entry_count;
  logic [RLEN_W-1:0]    stored_reply_length;

  modport source (output valid, status, entry_count, stored_reply_length, input ready);
  modport sink (input valid, status, entry_count, stored_reply_length, output ready);
endinterface

@@ hw/rtl/rdtt_front.sv @@
// Front end: holds the allowed-codes register, accepts request beats and
// classifies them into commands for the queue. Depends on rdtt_pkg, rdtt_in_if.
module rdtt_front import rdtt_pkg::*; #(
  parameter int NUM_CODES = DEF_NUM_CODES
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [WORD_W-1:0]  cfg_wdata,
  rdtt_in_if.sink            in_ch,
  input  logic               clr_busy,
  output logic               push_valid,
  input  logic               push_ready,
  output cmd_t               push_cmd
);

  localparam logic [CODE_W:0] NUM_CODES_W = (CODE_W+1)'(NUM_CODES);

  logic [WORD_W-1:0] allowed_r;
  logic              code_ok;
  kind_t             kind;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      allowed_r <= '0;
    end else if (cfg_we) begin
      allowed_r <= cfg_wdata;
    end
  end

  // code 0, codes past the table count or past the register, and disallowed codes
  assign code_ok = (in_ch.code != '0) && ({1'b0, in_ch.code} < NUM_CODES_W) &&
                   (in_ch.code[CODE_W-1:6] == '0) && allowed_r[in_ch.code[5:0]];

  always_comb begin
    unique case (in_ch.op)
      OP_INSERT: kind = (in_ch.stamp != '0) ? K_INS : K_LOOK;
      OP_DELETE: kind = K_DEL;
      OP_REPLY:  kind = K_RPL;
      default:   kind = K_LOOK;
    endcase
    if (!code_ok) begin
      kind = K_BAD;
    end
  end

  assign in_ch.ready = push_ready && !clr_busy;
  assign push_valid  = in_ch.valid && !clr_busy;

  always_comb begin
    push_cmd.kind         = kind;
    push_cmd.code         = in_ch.code;
    push_cmd.ident        = in_ch.ident;
    push_cmd.pkt_length   = in_ch.pkt_length;
    push_cmd.auth_hi      = in_ch.auth_hi;
    push_cmd.auth_lo      = in_ch.auth_lo;
    push_cmd.stamp        = in_ch.stamp;
    push_cmd.reply_length = in_ch.reply_length;
  end

endmodule

@@ hw/rtl/rdtt_queue.sv @@
// Short command FIFO between the front end and the table engine.
// Depends on rdtt_pkg.
module rdtt_queue import rdtt_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push_valid,
  output logic  push_ready,
  input  cmd_t  push_cmd,
  output logic  pop_valid,
  input  logic  pop_ready,
  output cmd_t  pop_cmd
);

  localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CW = $clog2(Q_DEPTH + 1);

  cmd_t            slot_r [Q_DEPTH];
  logic [PW-1:0]   wp_r, rp_r;
  logic [CW-1:0]   cnt_r;
  logic            do_push, do_pop;

  assign push_ready = (cnt_r != CW'(Q_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_cmd    = slot_r[rp_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wp_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= (wp_r == PW'(Q_DEPTH - 1)) ? '0 : wp_r + PW'(1);
      end
      if (do_pop) begin
        rp_r <= (rp_r == PW'(Q_DEPTH - 1)) ? '0 : rp_r + PW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

endmodule

@@ hw/rtl/rdtt_back.sv @@
// Table engine: entry memory with its post-reset clearing pass, read-modify-write
// of one entry per command, use counter and result register. Depends on rdtt_pkg,
// rdtt_out_if.
module rdtt_back import rdtt_pkg::*; #(
  parameter int NUM_CODES = DEF_NUM_CODES
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  pop_valid,
  output logic  pop_ready,
  input  cmd_t  pop_cmd,
  output logic  clr_busy,
  rdtt_out_if.source out_ch
);

  localparam int TBL_CODES = (NUM_CODES < MAX_CODES) ? NUM_CODES : MAX_CODES;
  localparam int TC_W      = $clog2(TBL_CODES);
  localparam int ID_W      = $clog2(IDS_PER_CODE);
  localparam int DEPTH     = TBL_CODES * IDS_PER_CODE;
  localparam int AW        = TC_W + ID_W;

  localparam logic [1:0] S_CLR  = 2'd0;
  localparam logic [1:0] S_IDLE = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;

  entry_t          mem [DEPTH];
  entry_t          rd_r;
  logic            re;
  logic [AW-1:0]   ra;
  logic            we;
  logic [AW-1:0]   wa;
  entry_t          wd;

  logic [1:0]          state_r, state_nxt;
  logic [AW-1:0]       clr_addr_r;
  cmd_t                cur_r;
  logic [COUNT_W-1:0]  cnt_r, cnt_nxt;
  logic                out_valid_r;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic [RLEN_W-1:0]   shown_r, shown_nxt;

  logic                used, match, stamp_hit, finish;
  logic [RLEN_W-1:0]   rlen_clip;
  entry_t              upd;
  logic                upd_we;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd_r <= mem[ra];
    end
  end

  assign clr_busy = (state_r == S_CLR);
  assign pop_ready = (state_r == S_IDLE);
  assign re = (state_r == S_IDLE) && pop_valid;
  assign ra = {pop_cmd.code[TC_W-1:0], pop_cmd.ident[ID_W-1:0]};
  assign finish = (state_r == S_EXEC) && (!out_valid_r || out_ch.ready);

  assign used      = (rd_r.ts != '0);
  assign match     = (rd_r.len == cur_r.pkt_length) && (rd_r.auth_hi == cur_r.auth_hi) &&
                     (rd_r.auth_lo == cur_r.auth_lo);
  assign stamp_hit = used && (rd_r.ts == cur_r.stamp);
  assign rlen_clip = (cur_r.reply_length > MAX_REPLY) ? MAX_REPLY : cur_r.reply_length;

  // Outcome of one command against the entry just read
  always_comb begin
    upd        = rd_r;
    upd_we     = 1'b0;
    cnt_nxt    = cnt_r;
    status_nxt = ST_ERR;
    shown_nxt  = rd_r.held_rlen;
    unique case (cur_r.kind)
      K_INS: begin
        upd.ts      = cur_r.stamp;
        upd.len     = cur_r.pkt_length;
        upd.auth_hi = cur_r.auth_hi;
        upd.auth_lo = cur_r.auth_lo;
        if (!used) begin
          upd_we     = 1'b1;
          cnt_nxt    = cnt_r + COUNT_W'(1);
          status_nxt = ST_NEW;
        end else if (match) begin
          status_nxt = ST_SAME;
        end else begin
          // replaced request loses its reply
          upd.held_rlen = '0;
          upd_we        = 1'b1;
          status_nxt    = ST_DIFF;
          shown_nxt     = '0;
        end
      end
      K_DEL: begin
        if (used) begin
          upd.ts        = '0;
          upd.held_rlen = '0;
          upd_we        = 1'b1;
          if (cnt_r != '0) begin
            cnt_nxt = cnt_r - COUNT_W'(1);
          end
          status_nxt = ST_OK;
          shown_nxt  = '0;
        end
      end
      K_RPL: begin
        status_nxt = ST_OK;
        if (stamp_hit) begin
          upd.held_rlen = rlen_clip;
          upd_we        = 1'b1;
          shown_nxt     = rlen_clip;
        end
      end
      K_LOOK: begin
        status_nxt = ST_ERR;
      end
      default: begin
        shown_nxt = '0;
      end
    endcase
  end

  always_comb begin
    we = 1'b0;
    wa = {cur_r.code[TC_W-1:0], cur_r.ident[ID_W-1:0]};
    wd = upd;
    if (state_r == S_CLR) begin
      we = 1'b1;
      wa = clr_addr_r;
      wd = '0;
    end else if (finish) begin
      we = upd_we;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLR:   if (clr_addr_r == AW'(DEPTH - 1)) state_nxt = S_IDLE;
      S_IDLE:  if (pop_valid) state_nxt = S_EXEC;
      S_EXEC:  if (finish) state_nxt = S_IDLE;
      default: state_nxt = S_CLR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_addr_r  <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLR) begin
        clr_addr_r <= clr_addr_r + AW'(1);
      end
      if (finish) begin
        cnt_r       <= cnt_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      cur_r <= pop_cmd;
    end
    if (finish) begin
      status_r <= status_nxt;
      shown_r  <= shown_nxt;
    end
  end

  assign out_ch.valid               = out_valid_r;
  assign out_ch.status              = status_r;
  assign out_ch.entry_count         = cnt_r;
  assign out_ch.stored_reply_length = shown_r;

endmodule

@@ hw/rtl/request_duplicate_tracking_table.sv @@
// Duplicate-request tracking table: one entry per packet code and identifier.
// Each request beat yields one result beat. An insert reports new, same (stored
// header matches) or different (header and stamp replaced, reply length dropped);
// a delete frees a used entry; a record-reply stores a reply length, capped at
// 4096, only while the entry's stamp equals the given one. Code 0, codes at or
// above NUM_CODES or 64, and codes whose bit in allowed_codes is clear give error.
// Timing: the front end takes a beat into a two-deep command queue in the cycle
// it arrives if the queue has room; the table engine reads the entry memory in
// its idle state, then compares and writes the entry back in its execute state,
// which waits while an earlier result is held and not yet taken. The engine takes
// no new command until it is through with the last one. After reset it clears
// the entry memory, one entry per cycle, all min(NUM_CODES,64)*256 entries (16384
// by default); no request beat is taken during that pass, configuration writes are.
// Depends on rdtt_pkg, rdtt_in_if, rdtt_out_if, rdtt_front, rdtt_queue, rdtt_back.
module request_duplicate_tracking_table import rdtt_pkg::*; #(
  parameter int NUM_CODES = DEF_NUM_CODES
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [WORD_W-1:0]  cfg_wdata,
  rdtt_in_if.sink            in_ch,
  rdtt_out_if.source         out_ch
);

  logic  push_valid, push_ready;
  cmd_t  push_cmd;
  logic  pop_valid, pop_ready;
  cmd_t  pop_cmd;
  logic  clr_busy;

  // classify requests; stalls only on a full queue or the clearing pass
  rdtt_front #(.NUM_CODES(NUM_CODES)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_ch      (in_ch),
    .clr_busy   (clr_busy),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  rdtt_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  // entry memory, counter and the result register
  rdtt_back #(.NUM_CODES(NUM_CODES)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_cmd   (pop_cmd),
    .clr_busy  (clr_busy),
    .out_ch    (out_ch)
  );

endmodule
